### rtl/lru_pkg.sv
// Shared types, constants and helper functions for the counter-based LRU block.
package lru_pkg;

  localparam int SET_COUNT    = 256;
  localparam int ASSOC        = 8;
  localparam int COUNTER_BITS = 8;

  localparam int SET_W     = 8;   // set_index field width
  localparam int WAY_W     = 3;   // way_index / victim_way field width
  localparam int SET_IDX_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_IDX_W = (ASSOC > 1) ? $clog2(ASSOC) : 1;

  typedef logic [COUNTER_BITS-1:0] counter_t;
  typedef counter_t [ASSOC-1:0]    row_t;

  localparam counter_t AGE_LIMIT = {COUNTER_BITS{1'b1}};
  localparam row_t     RESET_ROW = {ASSOC{counter_t'(1)}};

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_INVAL  = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PICK
  } state_t;

  function automatic counter_t bump(input counter_t v);
    bump = (v == AGE_LIMIT) ? AGE_LIMIT : v + counter_t'(1);
  endfunction

  // oldest way, lowest index on a tie; all-zero row gives way 0
  function automatic logic [WAY_W-1:0] pick_victim(input row_t row);
    counter_t          best;
    logic [WAY_W-1:0]  best_way;
    best     = '0;
    best_way = '0;
    for (int i = 0; i < ASSOC; i++) begin
      if (row[i] > best) begin
        best     = row[i];
        best_way = WAY_W'(i);
      end
    end
    pick_victim = best_way;
  endfunction

endpackage

### rtl/lru_row_update.sv
// Age counter update of one set row for an access or an invalidation.
module lru_row_update (
  input  lru_pkg::row_t            row,
  input  logic [1:0]               op,
  input  logic [lru_pkg::WAY_W-1:0] way,
  input  logic                     en,
  output lru_pkg::row_t            row_next
);
  import lru_pkg::*;

  logic [WAY_IDX_W-1:0] way_idx;
  counter_t             cur;
  counter_t             top;

  assign way_idx = way[WAY_IDX_W-1:0];
  assign cur     = row[way_idx];

  always_comb begin
    top = '0;
    for (int i = 0; i < ASSOC; i++) begin
      if (row[i] > top) top = row[i];
    end
  end

  always_comb begin
    row_next = row;
    if (en) begin
      case (op)
        OP_ACCESS: begin
          // a way already at zero is the youngest: nothing moves
          if (cur != '0) begin
            for (int i = 0; i < ASSOC; i++) begin
              if (WAY_IDX_W'(i) != way_idx && row[i] <= cur) row_next[i] = bump(row[i]);
            end
            row_next[way_idx] = '0;
          end
        end
        OP_INVAL: begin
          row_next[way_idx] = bump(top);
        end
        default: begin
          row_next = row;
        end
      endcase
    end
  end

endmodule

### rtl/lru_counter_replacement_policy_top.sv
// Top level: counter-based LRU replacement state with victim reporting.
//
// Input words (s_*) carry an opcode in s_tuser and a set/way pair in s_tdata:
// opcode 0 marks an access, 1 an invalidation, 2 or 3 only asks for the victim.
// Every input word yields exactly one output word (m_*) holding the victim way
// of the addressed set after the update: the way with the largest age counter,
// lowest index on a tie.
//
// The counters sit in a one-row-per-set synchronous RAM. An accepted word reads
// its row into a register; the update state computes the new row and writes it
// back; the victim is picked from the updated row and registered in the pick
// state once the output is free. No new word is taken until a word's read,
// update and write-back are done. The RAM write finishes before the next read
// is issued, so back-to-back words to the same set need no forwarding.
//
// Reset clears one valid bit per set; a set never written reads as all
// counters equal to one, so the block is ready in the cycle after reset.
// When m_tready is low the result holds in the output register; one more word
// may be accepted and updated, then the block waits until the output drains.
module lru_counter_replacement_policy_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // set_index[7:0], way_index[10:8], zero pad
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // victim_way[2:0], zero pad
);
  import lru_pkg::*;

  state_t state, state_next;

  logic [SET_W-1:0] in_set;
  logic [WAY_W-1:0] in_way;
  logic             s_accept;
  logic             out_free;
  logic             pick_load;

  logic [1:0]           op;
  logic [SET_IDX_W-1:0] set_addr;
  logic [WAY_W-1:0]     way;
  logic                 set_ok;
  logic                 way_ok;

  row_t                 mem [SET_COUNT];
  logic [SET_COUNT-1:0] row_valid;
  row_t                 rd_row;
  logic                 rd_valid;
  row_t                 row_in;
  row_t                 row_new;
  row_t                 row_hold;
  logic                 wr_en;

  logic [WAY_W-1:0] victim;

  assign in_set   = s_tdata[SET_W-1:0];
  assign in_way   = s_tdata[SET_W+WAY_W-1:SET_W];
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_accept) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_PICK;
      ST_PICK: begin
        if (out_free) state_next = s_accept ? ST_UPDATE : ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    wr_en     = 1'b0;
    pick_load = 1'b0;
    case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_UPDATE: wr_en = set_ok;
      ST_PICK: begin
        pick_load = out_free;
        s_tready  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // captured word
  always_ff @(posedge clk) begin
    if (s_accept) begin
      op       <= s_tuser;
      set_addr <= in_set[SET_IDX_W-1:0];
      way      <= in_way;
      set_ok   <= (32'(in_set) < SET_COUNT);
      way_ok   <= (32'(in_way) < ASSOC);
    end
  end

  // counter RAM, read at accept, written during the update cycle
  always_ff @(posedge clk) begin
    if (s_accept) rd_row <= mem[in_set[SET_IDX_W-1:0]];
    if (wr_en)    mem[set_addr] <= row_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[set_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) rd_valid <= row_valid[in_set[SET_IDX_W-1:0]];
  end

  assign row_in = rd_valid ? rd_row : RESET_ROW;

  lru_row_update u_update (
    .row      (row_in),
    .op       (op),
    .way      (way),
    .en       (set_ok && way_ok),
    .row_next (row_new)
  );

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) row_hold <= row_new;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pick_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pick_load) victim <= set_ok ? pick_victim(row_hold) : '0;
  end

  assign m_tdata = {5'b0, victim};

endmodule

### rtl/lru_checker.sv
// Port-level checks for the LRU block, bound to the top level.
module lru_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // every accepted word is followed by a valid output word (its own or an older one still held)
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##3 m_tvalid)
    else $error("no result after accepted word");

  // no input word is accepted back to back with the one before
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted in consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("output word changed while stalled");

endmodule

bind lru_counter_replacement_policy_top lru_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
